FILE: rtl/core/scbt_pkg.sv
// ----------------------------------------------------------------------------
// scbt_pkg
// Shared constants, codes and transaction layouts for the swap chain buffer
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package scbt_pkg;

    // table geometry and resize padding
    localparam int NUM_BUFFERS = 2;
    localparam int RESIZE_PAD  = 256;
    localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    // field widths
    localparam int ID_W     = 31;
    localparam int VIEW_W   = 14;
    localparam int ALLOC_W  = 15;
    localparam int COORD_W  = 16;
    localparam int DIM_IN_W = 15;
    localparam int DIM_W    = 16;

    // stream widths
    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 160;
    localparam int OUT_USER_W = 3;

    // buffer states
    localparam logic [1:0] BUF_AVAILABLE = 2'd0;
    localparam logic [1:0] BUF_RENDERING = 2'd1;
    localparam logic [1:0] BUF_PRESENTED = 2'd2;

    // operations
    localparam logic [1:0] OP_RESIZE   = 2'd0;
    localparam logic [1:0] OP_ACQUIRE  = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;
    localparam logic [1:0] OP_RELEASE  = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_NO_CHANGE = 3'd0;
    localparam logic [2:0] STAT_REALLOC   = 3'd1;
    localparam logic [2:0] STAT_GRANTED   = 3'd2;
    localparam logic [2:0] STAT_NONE_FREE = 3'd3;
    localparam logic [2:0] STAT_DONE      = 3'd4;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd5;
    localparam logic [2:0] STAT_ERROR     = 3'd6;

    // input transaction payload, last declared field in the lowest bits
    typedef struct packed {
        logic [4:0]                pad;
        logic                      wait_release;
        logic [ID_W-1:0]           buffer_id;
        logic [DIM_IN_W-1:0]       damage_h;
        logic [DIM_IN_W-1:0]       damage_w;
        logic signed [COORD_W-1:0] damage_y;
        logic signed [COORD_W-1:0] damage_x;
        logic                      resizing;
        logic [VIEW_W-1:0]         view_height;
        logic [VIEW_W-1:0]         view_width;
    } in_item_t;

    // result transaction payload, last declared field in the lowest bits
    typedef struct packed {
        logic [1:0]                pad;
        logic                      any_free;
        logic [DIM_W-1:0]          out_h;
        logic [DIM_W-1:0]          out_w;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_x;
        logic                      granted_index;
        logic [ID_W-1:0]           id_second;
        logic [ID_W-1:0]           id_first;
        logic [ALLOC_W-1:0]        size_height;
        logic [ALLOC_W-1:0]        size_width;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic             capture;
        logic             check;
        logic             scan;
        logic             grant;
        logic             load;
        logic [IDX_W-1:0] idx;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/scbt_ctrl.sv
// ----------------------------------------------------------------------------
// scbt_ctrl
// Sequencer: accept, check, scan over the buffer table, grant, hand off.
// ----------------------------------------------------------------------------
`default_nettype none

module scbt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          out_free,
    output scbt_pkg::cmd_t     cmd
);
    import scbt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_GRANT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             scan_last;

    assign scan_last = (cnt_reg == IDX_W'(NUM_BUFFERS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_SCAN;
                cnt_next   = '0;
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_GRANT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_GRANT: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // commands
    assign s_tready    = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.check   = (state_reg == S_CHECK);
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.grant   = (state_reg == S_GRANT);
    assign cmd.load    = (state_reg == S_DONE) && out_free;
    assign cmd.idx     = cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/core/scbt_datapath.sv
// ----------------------------------------------------------------------------
// scbt_datapath
// Buffer table, allocation state, damage union and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scbt_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_wdata,
    input  wire logic [1:0]                   in_op,
    input  wire scbt_pkg::in_item_t           in_item,
    input  wire scbt_pkg::cmd_t               cmd,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output scbt_pkg::out_item_t               out_item,
    output logic [2:0]                        out_status
);
    import scbt_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
    } dmg_t;

    // bounding box of two rectangles, empty operand passes the other
    function automatic dmg_t unite(input dmg_t a, input dmg_t b);
        dmg_t                      r;
        logic signed [COORD_W-1:0] l;
        logic signed [COORD_W-1:0] t;
        logic signed [17:0]        ar;
        logic signed [17:0]        br;
        logic signed [17:0]        ab;
        logic signed [17:0]        bb;
        logic signed [17:0]        rt;
        logic signed [17:0]        bt;
        logic signed [18:0]        wd;
        logic signed [18:0]        hd;
        l  = (a.x < b.x) ? a.x : b.x;
        t  = (a.y < b.y) ? a.y : b.y;
        ar = $signed({{2{a.x[15]}}, a.x}) + $signed({2'b00, a.w});
        br = $signed({{2{b.x[15]}}, b.x}) + $signed({2'b00, b.w});
        ab = $signed({{2{a.y[15]}}, a.y}) + $signed({2'b00, a.h});
        bb = $signed({{2{b.y[15]}}, b.y}) + $signed({2'b00, b.h});
        rt = (ar > br) ? ar : br;
        bt = (ab > bb) ? ab : bb;
        wd = $signed({rt[17], rt}) - $signed({{3{l[15]}}, l});
        hd = $signed({bt[17], bt}) - $signed({{3{t[15]}}, t});
        r.x = l;
        r.y = t;
        r.w = (wd > 19'sd65535) ? 16'hFFFF : wd[15:0];
        r.h = (hd > 19'sd65535) ? 16'hFFFF : hd[15:0];
        if (b.w == '0 || b.h == '0) begin
            r = a;
        end else if (a.w == '0 || a.h == '0) begin
            r = b;
        end
        return r;
    endfunction

    // control state
    logic                pub_first_reg;
    logic [ALLOC_W-1:0]  alloc_w_reg;
    logic [ALLOC_W-1:0]  alloc_h_reg;
    logic [ID_W-1:0]     next_id_reg;
    logic                table_valid_reg;
    logic [1:0]          state_reg [NUM_BUFFERS];
    logic                render_valid_reg;
    logic [IDX_W-1:0]    render_slot_reg;
    logic                latest_valid_reg;
    logic [IDX_W-1:0]    latest_slot_reg;
    logic                hit_reg;
    logic                found_reg;
    logic                m_tvalid_reg;

    // payload
    logic [ID_W-1:0]     id_reg [NUM_BUFFERS];
    dmg_t                dmg_reg [NUM_BUFFERS];
    logic [1:0]          op_reg;
    in_item_t            in_reg;
    out_item_t           res_reg;
    logic [2:0]          res_status_reg;
    out_item_t           out_reg;
    logic [2:0]          out_status_reg;

    // resize rule
    logic [ALLOC_W-1:0]  need_w;
    logic [ALLOC_W-1:0]  need_h;
    logic                force_match;
    logic                realloc;

    assign need_w = in_reg.resizing ? ALLOC_W'(in_reg.view_width) + ALLOC_W'(RESIZE_PAD)
                                    : ALLOC_W'(in_reg.view_width);
    assign need_h = in_reg.resizing ? ALLOC_W'(in_reg.view_height) + ALLOC_W'(RESIZE_PAD)
                                    : ALLOC_W'(in_reg.view_height);
    assign force_match = !in_reg.resizing &&
                         ((alloc_w_reg != need_w) || (alloc_h_reg != need_h));
    assign realloc = (in_reg.view_width != '0) && (in_reg.view_height != '0) &&
                     (force_match || alloc_w_reg == '0 || alloc_h_reg == '0 ||
                      need_w > alloc_w_reg || need_h > alloc_h_reg);

    // completion check
    logic complete_ok;

    assign complete_ok = render_valid_reg && table_valid_reg &&
                         (state_reg[render_slot_reg] == BUF_RENDERING) &&
                         (id_reg[render_slot_reg] == in_reg.buffer_id);

    // frame damage and united damage of the scanned entry
    dmg_t frame;
    dmg_t united;

    assign frame.x = in_reg.damage_x;
    assign frame.y = in_reg.damage_y;
    assign frame.w = {1'b0, in_reg.damage_w};
    assign frame.h = {1'b0, in_reg.damage_h};
    assign united  = unite(dmg_reg[cmd.idx], frame);

    // release match on the scanned entry
    logic rel_match;

    assign rel_match = (id_reg[cmd.idx] == in_reg.buffer_id) &&
                       (state_reg[cmd.idx] == BUF_PRESENTED);

    // first available entry and availability summary
    logic             g_found;
    logic [IDX_W-1:0] g_idx;
    logic             any_avail;

    always_comb begin
        g_found   = 1'b0;
        g_idx     = '0;
        any_avail = 1'b0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (state_reg[i] == BUF_AVAILABLE) begin
                any_avail = 1'b1;
                if (!g_found) begin
                    g_found = 1'b1;
                    g_idx   = IDX_W'(i);
                end
            end
        end
    end

    // result with the free flag of the table as it stands at hand-off
    out_item_t load_item;

    always_comb begin
        load_item          = res_reg;
        load_item.any_free = table_valid_reg && any_avail;
    end

    // control state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pub_first_reg    <= 1'b1;
            alloc_w_reg      <= '0;
            alloc_h_reg      <= '0;
            next_id_reg      <= '0;
            table_valid_reg  <= 1'b0;
            render_valid_reg <= 1'b0;
            render_slot_reg  <= '0;
            latest_valid_reg <= 1'b0;
            latest_slot_reg  <= '0;
            hit_reg          <= 1'b0;
            found_reg        <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                state_reg[i] <= BUF_AVAILABLE;
            end
        end else begin
            if (cfg_we) begin
                pub_first_reg <= cfg_wdata;
            end
            // per operation decision
            if (cmd.check) begin
                found_reg <= 1'b0;
                case (op_reg)
                    OP_RESIZE: begin
                        hit_reg <= realloc;
                        if (realloc) begin
                            alloc_w_reg      <= need_w;
                            alloc_h_reg      <= need_h;
                            table_valid_reg  <= 1'b1;
                            render_valid_reg <= 1'b0;
                            latest_valid_reg <= 1'b0;
                        end
                    end
                    OP_ACQUIRE: begin
                        hit_reg <= !render_valid_reg && table_valid_reg;
                    end
                    OP_COMPLETE: begin
                        hit_reg <= 1'b0;
                        if (complete_ok) begin
                            // same slot ends presented either way
                            if (!in_reg.wait_release && latest_valid_reg &&
                                latest_slot_reg != render_slot_reg) begin
                                state_reg[latest_slot_reg] <= BUF_AVAILABLE;
                            end
                            state_reg[render_slot_reg] <= BUF_PRESENTED;
                            latest_valid_reg <= 1'b1;
                            latest_slot_reg  <= render_slot_reg;
                            render_valid_reg <= 1'b0;
                        end
                    end
                    default: begin
                        hit_reg <= table_valid_reg;
                    end
                endcase
            end
            // table scan, one entry a cycle
            if (cmd.scan && hit_reg) begin
                case (op_reg)
                    OP_RESIZE: begin
                        next_id_reg <= next_id_reg + 1'b1;
                        state_reg[cmd.idx] <= (pub_first_reg && cmd.idx == '0)
                                              ? BUF_PRESENTED : BUF_AVAILABLE;
                    end
                    OP_RELEASE: begin
                        if (!found_reg && rel_match) begin
                            state_reg[cmd.idx] <= BUF_AVAILABLE;
                            found_reg          <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // grant of the first available buffer
            if (cmd.grant && hit_reg && op_reg == OP_ACQUIRE && g_found) begin
                state_reg[g_idx] <= BUF_RENDERING;
                render_valid_reg <= 1'b1;
                render_slot_reg  <= g_idx;
            end
        end
    end

    // capture, table payload and result assembly
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg  <= in_item;
            op_reg  <= in_op;
            res_reg <= '0;
        end
        if (cmd.check) begin
            case (op_reg)
                OP_RESIZE: begin
                    res_status_reg <= realloc ? STAT_REALLOC : STAT_NO_CHANGE;
                    if (realloc) begin
                        res_reg.size_width  <= need_w;
                        res_reg.size_height <= need_h;
                        res_reg.id_first    <= next_id_reg;
                        res_reg.id_second   <= next_id_reg + 1'b1;
                    end
                end
                OP_ACQUIRE: begin
                    res_status_reg <= render_valid_reg ? STAT_ERROR : STAT_NONE_FREE;
                end
                OP_COMPLETE: begin
                    res_status_reg <= complete_ok ? STAT_DONE : STAT_ERROR;
                end
                default: begin
                    res_status_reg <= STAT_NOT_FOUND;
                end
            endcase
        end
        if (cmd.scan && hit_reg) begin
            case (op_reg)
                OP_RESIZE: begin
                    id_reg[cmd.idx]    <= next_id_reg;
                    dmg_reg[cmd.idx].x <= '0;
                    dmg_reg[cmd.idx].y <= '0;
                    dmg_reg[cmd.idx].w <= {1'b0, alloc_w_reg};
                    dmg_reg[cmd.idx].h <= {1'b0, alloc_h_reg};
                end
                OP_ACQUIRE: begin
                    dmg_reg[cmd.idx] <= united;
                end
                OP_RELEASE: begin
                    if (!found_reg && rel_match) begin
                        res_status_reg <= STAT_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.grant && hit_reg && op_reg == OP_ACQUIRE && g_found) begin
            res_status_reg        <= STAT_GRANTED;
            res_reg.id_first      <= id_reg[g_idx];
            res_reg.granted_index <= g_idx[0];
            res_reg.out_x         <= dmg_reg[g_idx].x;
            res_reg.out_y         <= dmg_reg[g_idx].y;
            res_reg.out_w         <= dmg_reg[g_idx].w;
            res_reg.out_h         <= dmg_reg[g_idx].h;
            dmg_reg[g_idx]        <= '0;
        end
        if (cmd.load) begin
            out_reg        <= load_item;
            out_status_reg <= res_status_reg;
        end
    end

    // result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign out_item   = out_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

FILE: rtl/core/swap_chain_buffer_tracker.sv
// ----------------------------------------------------------------------------
// swap_chain_buffer_tracker
// Swap chain buffer table: resize reallocation, acquire with damage union,
// render completion and release by id.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_*       | in        | tuser: operation; tdata: resize, damage and id fields
//  m_*       | out       | tuser: status; tdata: sizes, ids, grant and damage
//  cfg_*     | in        | publish_first, written whenever cfg_we is high
//
//  after acceptance the sequencer runs check, a scan of one table entry per
//  cycle, grant and hand-off, which raises m_tvalid. s_tready returns in the
//  cycle after hand-off, so a new transaction is taken only after that.
//  the result sits in an output register; the next transaction is accepted
//  while it waits for m_tready, and its own hand-off stalls until it is taken.
//  reset is synchronous on aresetn low, and leaves publish_first set and every
//  buffer available with no table loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_chain_buffer_tracker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // view_width, view_height, resizing, damage_x, damage_y, damage_w,
    // damage_h, buffer_id, wait_release, zero pad
    input  wire logic [scbt_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation
    input  wire logic [scbt_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // size_width, size_height, id_first, id_second, granted_index, out_x,
    // out_y, out_w, out_h, any_free, zero pad
    output logic [scbt_pkg::OUT_DATA_W-1:0]        m_tdata,
    // status
    output logic [scbt_pkg::OUT_USER_W-1:0]        m_tuser
);
    import scbt_pkg::*;

    cmd_t      cmd;
    logic      out_free;
    in_item_t  in_item;
    out_item_t out_item;
    out_item_t out_packed;

    // input unpacking
    assign in_item = in_item_t'(s_tdata);

    // sequencer
    scbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    // buffer table and result register
    scbt_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_item    (in_item),
        .cmd        (cmd),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_item   (out_item),
        .out_status (m_tuser)
    );

    // output packing with zero fill
    always_comb begin
        out_packed     = out_item;
        out_packed.pad = '0;
    end

    assign m_tdata = OUT_DATA_W'(out_packed);

endmodule

`default_nettype wire

FILE: sim/tb_swap_chain_buffer_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swap_chain_buffer_tracker
// Self-checking bench for the swap chain buffer tracker. Resize, acquire,
// complete and release transactions are queued by a stimulus process and
// driven with random gaps. A behavioral copy of the buffer table predicts the
// result of each accepted transaction, and every result transaction is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_swap_chain_buffer_tracker;
    import scbt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 16;

    // how the id of a complete or release is chosen when it goes on the bus
    typedef enum int {
        PICK_RAW,
        PICK_RENDERING,
        PICK_PRESENTED,
        PICK_NEAR
    } id_pick_e;

    typedef struct {
        logic [1:0] op;
        in_item_t   item;
        id_pick_e   pick;
    } table_event_t;

    typedef struct {
        logic [2:0] status;
        out_item_t  fields;
    } table_report_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
    } damage_t;

    // dut ports
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // stimulus and checking bookkeeping
    table_event_t  queued_events [$];
    table_report_t due_reports [$];
    logic [1:0]    live_op;
    in_item_t      live_item;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            mismatches = 0;
    int            cycle_count = 0;

    // shadow of the buffer table
    logic             publish_first_q;
    logic [ALLOC_W-1:0] alloc_w;
    logic [ALLOC_W-1:0] alloc_h;
    logic [ID_W-1:0]  next_id;
    logic             table_loaded;
    logic [1:0]       buf_state [NUM_BUFFERS];
    logic [ID_W-1:0]  buf_ids [NUM_BUFFERS];
    damage_t          buf_dmg [NUM_BUFFERS];
    logic             rendering;
    int               render_idx;
    logic             presented_known;
    int               latest_idx;

    swap_chain_buffer_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // bounding box of two damage rectangles, empty operands pass through
    function automatic damage_t merge_damage(damage_t a, damage_t b);
        int      left, top, right, bottom;
        damage_t r;
        if (b.w == 0 || b.h == 0) return a;
        if (a.w == 0 || a.h == 0) return b;
        left   = (a.x < b.x) ? int'(a.x) : int'(b.x);
        top    = (a.y < b.y) ? int'(a.y) : int'(b.y);
        right  = int'(a.x) + int'(a.w);
        if (int'(b.x) + int'(b.w) > right) right = int'(b.x) + int'(b.w);
        bottom = int'(a.y) + int'(a.h);
        if (int'(b.y) + int'(b.h) > bottom) bottom = int'(b.y) + int'(b.h);
        r.x = COORD_W'(left);
        r.y = COORD_W'(top);
        r.w = (right - left > 65535) ? 16'hFFFF : DIM_W'(right - left);
        r.h = (bottom - top > 65535) ? 16'hFFFF : DIM_W'(bottom - top);
        return r;
    endfunction

    // advance the shadow table by one transaction and form its result
    function automatic void table_step(input logic [1:0] op, input in_item_t it,
                                       output table_report_t rep);
        logic [ALLOC_W-1:0] need_w, need_h;
        logic               exact_miss;
        logic               found;
        damage_t            frame;
        int                 i;
        rep.status = STAT_NO_CHANGE;
        rep.fields = '0;
        found = 1'b0;
        case (op)
            OP_RESIZE: begin
                if (it.view_width != 0 && it.view_height != 0) begin
                    need_w = ALLOC_W'(it.view_width);
                    need_h = ALLOC_W'(it.view_height);
                    if (it.resizing) begin
                        need_w = need_w + ALLOC_W'(RESIZE_PAD);
                        need_h = need_h + ALLOC_W'(RESIZE_PAD);
                    end
                    exact_miss = !it.resizing && (alloc_w != need_w || alloc_h != need_h);
                    if (exact_miss || alloc_w == 0 || alloc_h == 0 ||
                        need_w > alloc_w || need_h > alloc_h) begin
                        alloc_w = need_w;
                        alloc_h = need_h;
                        for (i = 0; i < NUM_BUFFERS; i++) begin
                            buf_ids[i] = next_id;
                            next_id = next_id + 1'b1;
                            buf_state[i] = (publish_first_q && i == 0) ? BUF_PRESENTED
                                                                       : BUF_AVAILABLE;
                            buf_dmg[i].x = '0;
                            buf_dmg[i].y = '0;
                            buf_dmg[i].w = DIM_W'(alloc_w);
                            buf_dmg[i].h = DIM_W'(alloc_h);
                        end
                        table_loaded    = 1'b1;
                        rendering       = 1'b0;
                        presented_known = 1'b0;
                        rep.status             = STAT_REALLOC;
                        rep.fields.size_width  = alloc_w;
                        rep.fields.size_height = alloc_h;
                        rep.fields.id_first    = buf_ids[0];
                        rep.fields.id_second   = buf_ids[1];
                    end
                end
            end
            OP_ACQUIRE: begin
                if (rendering) begin
                    rep.status = STAT_ERROR;
                end else if (!table_loaded) begin
                    rep.status = STAT_NONE_FREE;
                end else begin
                    frame.x = it.damage_x;
                    frame.y = it.damage_y;
                    frame.w = DIM_W'(it.damage_w);
                    frame.h = DIM_W'(it.damage_h);
                    for (i = 0; i < NUM_BUFFERS; i++)
                        buf_dmg[i] = merge_damage(buf_dmg[i], frame);
                    rep.status = STAT_NONE_FREE;
                    for (i = 0; i < NUM_BUFFERS; i++) begin
                        if (!found && buf_state[i] == BUF_AVAILABLE) begin
                            found        = 1'b1;
                            buf_state[i] = BUF_RENDERING;
                            rendering    = 1'b1;
                            render_idx   = i;
                            rep.status               = STAT_GRANTED;
                            rep.fields.id_first      = buf_ids[i];
                            rep.fields.granted_index = i[0];
                            rep.fields.out_x         = buf_dmg[i].x;
                            rep.fields.out_y         = buf_dmg[i].y;
                            rep.fields.out_w         = buf_dmg[i].w;
                            rep.fields.out_h         = buf_dmg[i].h;
                            buf_dmg[i] = '{'0, '0, '0, '0};
                        end
                    end
                end
            end
            OP_COMPLETE: begin
                if (!rendering || !table_loaded || buf_state[render_idx] != BUF_RENDERING ||
                    buf_ids[render_idx] != it.buffer_id) begin
                    rep.status = STAT_ERROR;
                end else begin
                    if (!it.wait_release && presented_known)
                        buf_state[latest_idx] = BUF_AVAILABLE;
                    buf_state[render_idx] = BUF_PRESENTED;
                    presented_known = 1'b1;
                    latest_idx      = render_idx;
                    rendering       = 1'b0;
                    rep.status      = STAT_DONE;
                end
            end
            OP_RELEASE: begin
                rep.status = STAT_NOT_FOUND;
                if (table_loaded) begin
                    for (i = 0; i < NUM_BUFFERS; i++) begin
                        if (!found && buf_ids[i] == it.buffer_id &&
                            buf_state[i] == BUF_PRESENTED) begin
                            found        = 1'b1;
                            buf_state[i] = BUF_AVAILABLE;
                            rep.status   = STAT_DONE;
                        end
                    end
                end
            end
            default: ;
        endcase
        // free flag reflects the table after the step
        rep.fields.any_free = 1'b0;
        if (table_loaded)
            for (i = 0; i < NUM_BUFFERS; i++)
                if (buf_state[i] == BUF_AVAILABLE) rep.fields.any_free = 1'b1;
    endfunction

    // fill in the id of a complete or release from the table as it stands now
    function automatic logic [ID_W-1:0] resolve_id(id_pick_e pick, logic [ID_W-1:0] raw);
        int hits [$];
        int i;
        int slot;
        case (pick)
            PICK_RENDERING: begin
                if (rendering) return buf_ids[render_idx];
            end
            PICK_PRESENTED: begin
                for (i = 0; i < NUM_BUFFERS; i++)
                    if (table_loaded && buf_state[i] == BUF_PRESENTED) hits.push_back(i);
                if (hits.size() != 0) return buf_ids[hits[$urandom_range(hits.size() - 1)]];
            end
            PICK_NEAR: begin
                slot = rendering ? render_idx : $urandom_range(NUM_BUFFERS - 1);
                if (table_loaded) return buf_ids[slot] ^ (ID_W'(1) << $urandom_range(ID_W - 1));
            end
            default: ;
        endcase
        return raw;
    endfunction

    // every field random, padding zero
    function automatic in_item_t noise_item();
        in_item_t it;
        it              = '0;
        it.view_width   = VIEW_W'($urandom);
        it.view_height  = VIEW_W'($urandom);
        it.resizing     = 1'($urandom_range(1));
        it.damage_x     = COORD_W'($urandom);
        it.damage_y     = COORD_W'($urandom);
        it.damage_w     = DIM_IN_W'($urandom);
        it.damage_h     = DIM_IN_W'($urandom);
        it.buffer_id    = ID_W'($urandom);
        it.wait_release = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic void add_event(logic [1:0] op, in_item_t it, id_pick_e pick);
        table_event_t ev;
        ev.op   = op;
        ev.item = it;
        ev.pick = pick;
        queued_events.push_back(ev);
    endfunction

    function automatic void add_resize(int w, int h, bit rs);
        in_item_t it;
        it             = noise_item();
        it.view_width  = VIEW_W'(w);
        it.view_height = VIEW_W'(h);
        it.resizing    = rs;
        add_event(OP_RESIZE, it, PICK_RAW);
    endfunction

    function automatic void add_acquire(int x, int y, int w, int h);
        in_item_t it;
        it          = noise_item();
        it.damage_x = COORD_W'(x);
        it.damage_y = COORD_W'(y);
        it.damage_w = DIM_IN_W'(w);
        it.damage_h = DIM_IN_W'(h);
        add_event(OP_ACQUIRE, it, PICK_RAW);
    endfunction

    function automatic void add_complete(id_pick_e pick, bit hold_prev);
        in_item_t it;
        it              = noise_item();
        it.wait_release = hold_prev;
        add_event(OP_COMPLETE, it, pick);
    endfunction

    function automatic void add_release(id_pick_e pick, logic [ID_W-1:0] raw);
        in_item_t it;
        it           = noise_item();
        it.buffer_id = raw;
        add_event(OP_RELEASE, it, pick);
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(3) == 0) return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(100)) - 50;
    endfunction

    function automatic int rand_dim();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r < 3) return $urandom_range(32767);
        return $urandom_range(1, 100);
    endfunction

    function automatic int rand_view();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 0;
        if (r == 1) return 16383;
        if (r == 2) return $urandom_range(16383);
        return $urandom_range(1, 3);
    endfunction

    // mostly acquire / complete / release frames, with resizes and noise mixed in
    function automatic void add_random(int count);
        int made;
        int r;
        made = 0;
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 10) begin
                add_resize(rand_view(), rand_view(), 1'($urandom_range(1)));
                made++;
            end else if (r < 75) begin
                add_acquire(rand_coord(), rand_coord(), rand_dim(), rand_dim());
                add_complete(PICK_RENDERING, $urandom_range(3) == 0);
                made += 2;
                if ($urandom_range(2) == 0) begin
                    add_release(PICK_PRESENTED, ID_W'($urandom));
                    made++;
                end
            end else if (r < 85) begin
                add_release(PICK_PRESENTED, ID_W'($urandom));
                made++;
            end else begin
                add_event(2'($urandom), noise_item(),
                          $urandom_range(1) ? PICK_NEAR : PICK_RAW);
                made++;
            end
        end
    endfunction

    // block until no transaction is queued, in flight or awaiting its result
    task automatic wait_drained();
        while (queued_events.size() != 0 || s_tvalid || due_reports.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_publish_first(logic value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        publish_first_q = value;
    endtask

    // input driver: predict on acceptance, then present the next queued transaction
    always @(posedge aclk) begin
        table_event_t  nxt;
        table_report_t rep;
        logic          busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                table_step(live_op, live_item, rep);
                due_reports.push_back(rep);
                busy = 1'b0;
            end
            if (!busy) begin
                if (queued_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = queued_events.pop_front();
                    nxt.item.buffer_id = resolve_id(nxt.pick, nxt.item.buffer_id);
                    live_op   = nxt.op;
                    live_item = nxt.item;
                    s_tuser  <= nxt.op;
                    s_tdata  <= nxt.item;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(string name, longint want, longint seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endfunction

    // result monitor
    always @(posedge aclk) begin
        table_report_t want;
        out_item_t     seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (due_reports.size() == 0) begin
                $error("result transaction with nothing pending, status %0d", m_tuser);
                mismatches++;
            end else begin
                want = due_reports.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("size_width", want.fields.size_width, seen.size_width);
                check_field("size_height", want.fields.size_height, seen.size_height);
                check_field("id_first", want.fields.id_first, seen.id_first);
                check_field("id_second", want.fields.id_second, seen.id_second);
                check_field("granted_index", want.fields.granted_index, seen.granted_index);
                check_field("out_x", want.fields.out_x, seen.out_x);
                check_field("out_y", want.fields.out_y, seen.out_y);
                check_field("out_w", want.fields.out_w, seen.out_w);
                check_field("out_h", want.fields.out_h, seen.out_h);
                check_field("any_free", want.fields.any_free, seen.any_free);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        publish_first_q = 1'b1;
        alloc_w         = '0;
        alloc_h         = '0;
        next_id         = '0;
        table_loaded    = 1'b0;
        rendering       = 1'b0;
        render_idx      = 0;
        presented_known = 1'b0;
        latest_idx      = 0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            buf_state[i] = BUF_AVAILABLE;
            buf_ids[i]   = '0;
            buf_dmg[i]   = '{'0, '0, '0, '0};
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 26;
        recv_idle_pct = 56;
        write_publish_first(1'b1);

        // no table loaded yet
        add_acquire(5, 5, 10, 10);
        add_complete(PICK_RENDERING, 1'b0);
        add_release(PICK_PRESENTED, '0);
        // empty viewport, then exact allocation and a repeat of it
        add_resize(0, 5, 1'b0);
        add_resize(5, 0, 1'b1);
        add_resize(100, 50, 1'b0);
        add_resize(100, 50, 1'b0);
        // largest padded allocation, then a smaller one while resizing
        add_resize(16383, 16383, 1'b1);
        add_resize(200, 200, 1'b1);
        // grant with extreme damage, acquire while rendering, wrong id
        add_acquire(-32768, -32768, 32767, 32767);
        add_acquire(0, 0, 1, 1);
        add_complete(PICK_NEAR, 1'b0);
        add_complete(PICK_RENDERING, 1'b1);
        // nothing free; damage saturates on the far corner
        add_acquire(32767, 32767, 32767, 32767);
        add_release(PICK_PRESENTED, '0);
        add_release(PICK_RAW, buf_ids[0]);
        add_acquire(1, 1, 0, 9);
        add_complete(PICK_RENDERING, 1'b0);
        add_acquire(3, 3, 9, 0);
        add_complete(PICK_RENDERING, 1'b0);
        add_release(PICK_RAW, {ID_W{1'b1}});
        // exact match forces shrinking reallocation
        add_resize(1, 1, 1'b0);
        add_resize(16383, 16383, 1'b0);
        wait_drained();

        add_random(200);
        wait_drained();
        add_random(200);
        wait_drained();

        // roles swapped, buffers all start free
        write_publish_first(1'b0);
        send_idle_pct = 56;
        recv_idle_pct = 26;
        add_random(200);
        wait_drained();
        add_random(200);
        wait_drained();

        // full rate both ways
        write_publish_first(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(400);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/scbt_pkg.sv
rtl/core/scbt_ctrl.sv
rtl/core/scbt_datapath.sv
rtl/core/swap_chain_buffer_tracker.sv
sim/tb_swap_chain_buffer_tracker.sv
